/* src/fhsbc_pkg.sv */
package fhsbc_pkg;
  localparam int unsigned SlotsDefault = 2048;
  localparam logic [31:0] HashMul = 32'd2654435761;
  localparam logic [63:0] SumInit = 64'd1469598103934665603;
  localparam logic [63:0] SumMul = 64'd1099511628211;
  localparam logic [31:0] WhiteReset = 32'hC0C00000;
  localparam logic [31:0] GreyReset = 32'hC1600000;
  localparam logic [31:0] StampMax = 32'hFFFFFFFF;
  localparam logic [31:0] StampInit = 32'd1;

  typedef enum logic {
    OP_PUT = 1'b0,
    OP_GET = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    BAND_BLACK = 2'd0,
    BAND_GREY  = 2'd1,
    BAND_WHITE = 2'd2
  } band_t;

  typedef enum logic {
    REG_WHITE = 1'b0,
    REG_GREY  = 1'b1
  } reg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;  // write empty key at sweep address
    logic load;        // capture item and its hash
    logic sum_mix;     // xor key and reading into checksum
    logic sum_mul;     // multiply checksum
    logic home;        // point probe address at home slot
    logic rd;          // read probe slot
    logic eval;        // compare read row, track eviction candidate
    logic advance;     // step probe address
    logic use_ev;      // point probe address at eviction candidate
    logic wr_row;      // write key, reading, stamp at probe address
    logic band_old;    // take away the old reading's band
    logic band_new;    // add the new reading's band
    logic live_inc;
    logic get_hit;     // latch found and read value
    logic out_load;    // capture result
  } fhsbc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_get;
    logic empty;
    logic match;
    logic have_ev;
    logic last_probe;
    logic sweep_done;
  } fhsbc_sts_t;

  function automatic logic fhsbc_is_nan(input logic [31:0] x);
    return x[30:0] > 31'h7F800000;
  endfunction

  function automatic logic [31:0] fhsbc_order(input logic [31:0] x);
    logic [31:0] y;
    y = (x[30:0] == 31'd0) ? 32'd0 : x;
    return y[31] ? ~y : (y | 32'h80000000);
  endfunction

  function automatic logic fhsbc_ge(input logic [31:0] a, input logic [31:0] b);
    if (fhsbc_is_nan(a) || fhsbc_is_nan(b)) return 1'b0;
    return fhsbc_order(a) >= fhsbc_order(b);
  endfunction

  function automatic band_t fhsbc_band(input logic [31:0] r, input logic [31:0] w,
                                       input logic [31:0] g);
    if (fhsbc_ge(r, w)) return BAND_WHITE;
    if (fhsbc_ge(r, g)) return BAND_GREY;
    return BAND_BLACK;
  endfunction
endpackage

/* src/fixed_hash_store_band_counts.sv */
// Each item probes from its home slot on, passing S_READ, S_WAIT and S_EVAL per slot;
// a put to an empty slot then takes S_WRITE and S_NEW; one that updates its key adds S_OLD.
// A put on a full table evicts the oldest row via S_EVSEL and S_EVREAD, else is dropped.
// Throughput: one item at a time; the next item is taken at the earliest at the edge that
// takes the result. Reset (rst, synchronous) clears the key store; s_axis_tready rises
// once the clear sweep has written every slot.
module fixed_hash_store_band_counts
  import fhsbc_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // key, reading_bits
  input  logic         s_axis_tuser,   // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [207:0] m_axis_tdata,   // read_value, live_rows, black_count, grey_count,
                                       // white_count, checksum, total_puts
  output logic         m_axis_tuser,   // found
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);
  fhsbc_cmd_t cmd;
  fhsbc_sts_t sts;

  fhsbc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .sts(sts), .cmd(cmd),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready)
  );

  fhsbc_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_op(s_axis_tuser), .in_key(s_axis_tdata[31:0]), .in_reading(s_axis_tdata[63:32]),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .res_found(m_axis_tuser), .res_data(m_axis_tdata)
  );
endmodule

/* src/fhsbc_datapath.sv */
module fhsbc_datapath
  import fhsbc_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  fhsbc_cmd_t   cmd,
  output fhsbc_sts_t   sts,
  input  logic         in_op,
  input  logic [31:0]  in_key,
  input  logic [31:0]  in_reading,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  output logic         res_found,
  output logic [207:0] res_data
);
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  // floor(2^(32+AW) / SLOTS) + 1 gives the exact quotient of any 32-bit hash
  localparam logic [32:0] Recip = 33'(((64'd1 << (32 + AW)) / 64'(SLOTS)) + 64'd1);

  logic [31:0] mem_key [SLOTS];
  logic [31:0] mem_reading [SLOTS];
  logic [31:0] mem_stamp [SLOTS];

  logic [31:0] white_thr, grey_thr;
  logic        op;
  logic [31:0] key, reading;
  logic [AW-1:0] addr, ev_addr, sweep;
  logic [CW-1:0] probes;
  logic        sweep_done;
  logic [31:0] rd_key, rd_reading, rd_stamp;
  logic [31:0] ev_stamp;
  logic        have_ev;
  logic [31:0] next_stamp;
  logic [11:0] live, black, grey, white;
  logic [63:0] sum, puts, mixed, mix_in;
  logic        found;
  logic [31:0] read_value;
  logic [31:0] hash;
  logic [31:0] hash_q, quot, home;
  logic [64:0] prod;
  logic [31:0] key_m;
  band_t       band_sel;
  logic [31:0] band_src;

  // times 0x1B3; the checksum prime is 2^40 + 0x1B3
  function automatic logic [63:0] mul_low(input logic [63:0] x);
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8);
  endfunction

  assign key_m = (in_key == 32'd0) ? 32'd1 : in_key;
  assign hash = key_m * HashMul;
  assign prod = {33'd0, hash_q} * {32'd0, Recip};
  assign home = hash_q - (quot * 32'(SLOTS));
  assign mix_in = sum ^ ({32'd0, key} ^ {31'd0, reading, 1'b0});

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mem_key[sweep] <= 32'd0;
    end else if (cmd.wr_row) begin
      mem_key[addr] <= key;
      mem_reading[addr] <= reading;
      mem_stamp[addr] <= next_stamp;
    end
    if (cmd.rd) begin
      rd_key <= mem_key[addr];
      rd_reading <= mem_reading[addr];
      rd_stamp <= mem_stamp[addr];
    end
  end

  assign band_src = cmd.band_old ? rd_reading : reading;
  assign band_sel = fhsbc_band(band_src, white_thr, grey_thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      white_thr <= WhiteReset;
      grey_thr <= GreyReset;
      sweep <= '0;
      sweep_done <= 1'b0;
      next_stamp <= StampInit;
      live <= '0;
      black <= '0;
      grey <= '0;
      white <= '0;
      sum <= SumInit;
      puts <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WHITE) white_thr <= cfg_data;
        else grey_thr <= cfg_data;
      end
      if (cmd.clear_step) begin
        if (sweep == AW'(SLOTS - 1)) sweep_done <= 1'b1;
        else sweep <= sweep + 1'b1;
      end
      if (cmd.sum_mix) begin
        sum <= mix_in;
        puts <= puts + 64'd1;
      end else if (cmd.sum_mul) begin
        sum <= mixed + {sum[23:0], 40'd0};
      end
      if (cmd.wr_row) next_stamp <= next_stamp + 32'd1;
      if (cmd.live_inc) live <= live + 12'd1;
      if (cmd.band_old || cmd.band_new) begin
        case (band_sel)
          BAND_WHITE: white <= cmd.band_old ? white - 12'd1 : white + 12'd1;
          BAND_GREY:  grey <= cmd.band_old ? grey - 12'd1 : grey + 12'd1;
          default:    black <= cmd.band_old ? black - 12'd1 : black + 12'd1;
        endcase
      end
    end
  end

  // low part of the checksum product and the home slot quotient, one register each
  always_ff @(posedge clk) begin
    mixed <= mul_low(mix_in);
    quot <= 32'(prod >> (32 + AW));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_op;
      key <= key_m;
      reading <= in_reading;
      hash_q <= hash;
      probes <= '0;
      have_ev <= 1'b0;
      ev_stamp <= StampMax;
      found <= 1'b0;
      read_value <= '0;
    end
    if (cmd.home) addr <= home[AW-1:0];
    if (cmd.eval && rd_stamp < ev_stamp) begin
      ev_stamp <= rd_stamp;
      ev_addr <= addr;
      have_ev <= 1'b1;
    end
    if (cmd.advance) begin
      addr <= (addr == AW'(SLOTS - 1)) ? '0 : addr + 1'b1;
      probes <= probes + 1'b1;
    end
    if (cmd.use_ev) addr <= ev_addr;
    if (cmd.get_hit) begin
      found <= 1'b1;
      read_value <= rd_reading;
    end
    if (cmd.out_load) begin
      res_found <= found;
      res_data <= {puts, sum, white, grey, black, live, read_value};
    end
  end

  assign sts.is_get = (op == OP_GET);
  assign sts.empty = (rd_key == 32'd0);
  assign sts.match = (rd_key == key);
  assign sts.have_ev = have_ev;
  assign sts.last_probe = (probes == CW'(SLOTS - 1));
  assign sts.sweep_done = sweep_done;
endmodule

/* src/fhsbc_ctrl.sv */
module fhsbc_ctrl
  import fhsbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  fhsbc_sts_t sts,
  output fhsbc_cmd_t cmd,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_FOLD, S_READ, S_WAIT, S_EVAL, S_EVSEL, S_EVREAD, S_OLD,
    S_WRITE, S_NEW, S_OUT
  } state_t;

  state_t state;
  logic   in_fire;
  logic   out_hold;

  assign out_hold = out_valid && !out_ready;
  assign in_ready = (state == S_IDLE) && !out_hold;
  assign in_fire = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    case (state)
      S_CLEAR: cmd.clear_step = !sts.sweep_done;
      S_IDLE:  cmd.load = in_fire;
      S_MUL:   cmd.sum_mix = !sts.is_get;
      S_FOLD: begin
        cmd.sum_mul = !sts.is_get;
        cmd.home = 1'b1;
      end
      S_READ:  cmd.rd = 1'b1;
      S_EVAL: begin
        if (sts.empty) begin
          cmd.live_inc = !sts.is_get;
        end else if (sts.match) begin
          cmd.get_hit = sts.is_get;
        end else begin
          cmd.eval = 1'b1;
          cmd.advance = !sts.last_probe;
        end
      end
      S_EVSEL:  cmd.use_ev = sts.have_ev;
      S_EVREAD: cmd.rd = 1'b1;
      S_OLD:   cmd.band_old = 1'b1;
      S_WRITE: cmd.wr_row = 1'b1;
      S_NEW:   cmd.band_new = 1'b1;
      S_OUT:   cmd.out_load = !out_hold;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && !out_hold) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: if (sts.sweep_done) state <= S_IDLE;
        S_IDLE:  if (in_fire) state <= S_MUL;
        S_MUL:   state <= S_FOLD;
        S_FOLD:  state <= S_READ;
        S_READ:  state <= S_WAIT;
        S_WAIT:  state <= S_EVAL;
        S_EVAL: begin
          if (sts.empty) begin
            state <= sts.is_get ? S_OUT : S_WRITE;
          end else if (sts.match) begin
            state <= sts.is_get ? S_OUT : S_OLD;
          end else if (sts.last_probe) begin
            // full table: evict oldest, or drop if none
            state <= sts.is_get ? S_OUT : S_EVSEL;
          end else begin
            state <= S_READ;
          end
        end
        S_EVSEL:  state <= sts.have_ev ? S_EVREAD : S_OUT;
        S_EVREAD: state <= S_OLD;
        S_OLD:   state <= S_WRITE;
        S_WRITE: state <= S_NEW;
        S_NEW:   state <= S_OUT;
        S_OUT: begin
          if (!out_hold) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
